[rtl/primitive_triangle_assembler_defines.svh]
// Assertion macros shared by the primitive triangle assembler modules.
// Users must have clk and rst in scope; no other dependencies.
`ifndef PRIMITIVE_TRIANGLE_ASSEMBLER_DEFINES_SVH
`define PRIMITIVE_TRIANGLE_ASSEMBLER_DEFINES_SVH

// Property that must hold at every edge outside reset.
`define PTA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define PTA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/pta_pkg.sv]
// Shared types and constants for the primitive triangle assembler.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package pta_pkg;

  // Fixed widths of the vertex and kind fields.
  localparam int VTX_BITS  = 16;
  localparam int KIND_BITS = 3;

  // Depth of the job queue between front and back.
  localparam int QDEPTH = 4;

  // Primitive kinds; every other code is unsupported.
  typedef enum logic [KIND_BITS-1:0] {
    KIND_LIST  = 3'd0,
    KIND_STRIP = 3'd1,
    KIND_FAN   = 3'd2,
    KIND_QUADS = 3'd3
  } prim_kind_e_t;

  // Control flags carried with each queued job.
  typedef struct packed {
    logic two;   // job yields two triangles (quad)
    logic skip;  // job is a skip word for an unsupported primitive
  } job_flags_t;

endpackage

[rtl/pta_front.sv]
// Front end: accepts vertex words, tracks primitive state and forms jobs.
// Depends on pta_pkg.
`timescale 1ns / 1ps
module pta_front import pta_pkg::*; #(
  parameter int HB = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [VTX_BITS-1:0]  vertex_handle,
  input  logic [KIND_BITS-1:0] prim_kind,
  input  logic                 prim_first,
  input  logic                 prim_last,
  input  logic                 q_full,
  output logic                 push,
  output logic [HB-1:0]        job_h0,
  output logic [HB-1:0]        job_h1,
  output logic [HB-1:0]        job_h2,
  output logic [HB-1:0]        job_h3,
  output job_flags_t           job_flags
);

  logic [HB-1:0] anchor, anchor_next;
  logic [HB-1:0] older, older_next;
  logic [HB-1:0] newer, newer_next;
  logic [1:0]    pos, pos_next;
  prim_kind_e_t  open_kind, kind_eff;
  logic [1:0]    pos_eff;
  logic [HB-1:0] v;
  logic          accept;
  logic          emit;

  // A word is taken whenever the queue has room.
  assign in_ready = !q_full;
  assign accept   = in_valid && !q_full;
  assign push     = accept && emit;

  // A start marker latches the kind and restarts the position count.
  assign v        = vertex_handle[HB-1:0];
  assign kind_eff = prim_first ? prim_kind_e_t'(prim_kind) : open_kind;
  assign pos_eff  = prim_first ? 2'd0 : pos;

  // Classify the vertex and work out the next primitive state.
  always_comb begin
    anchor_next = anchor;
    older_next  = older;
    newer_next  = newer;
    pos_next    = pos_eff;
    emit        = 1'b0;
    job_h0      = older;
    job_h1      = newer;
    job_h2      = v;
    job_h3      = v;
    job_flags   = '0;
    unique case (kind_eff) inside
      KIND_LIST, KIND_STRIP: begin
        emit       = (pos_eff == 2'd2);
        older_next = newer;
        newer_next = v;
        if (pos_eff == 2'd2) begin
          pos_next = (kind_eff == KIND_LIST) ? 2'd0 : 2'd2;
        end else begin
          pos_next = pos_eff + 2'd1;
        end
      end
      KIND_FAN: begin
        if (pos_eff == 2'd0) begin
          anchor_next = v;
          pos_next    = 2'd1;
        end else if (pos_eff == 2'd1) begin
          newer_next = v;
          pos_next   = 2'd2;
        end else begin
          emit       = 1'b1;
          job_h0     = anchor;
          job_h1     = newer;
          newer_next = v;
          pos_next   = 2'd2;
        end
      end
      KIND_QUADS: begin
        job_h0 = anchor;
        job_h1 = older;
        job_h2 = newer;
        job_h3 = v;
        if (pos_eff == 2'd0) begin
          anchor_next = v;
          pos_next    = 2'd1;
        end else if (pos_eff == 2'd1) begin
          older_next = v;
          pos_next   = 2'd2;
        end else if (pos_eff == 2'd2) begin
          newer_next = v;
          pos_next   = 2'd3;
        end else begin
          emit          = 1'b1;
          job_flags.two = 1'b1;
          pos_next      = 2'd0;
        end
      end
      default: begin
        emit           = prim_last;
        job_flags.skip = 1'b1;
        pos_next       = 2'd0;
      end
    endcase
    if (prim_last) begin
      pos_next = 2'd0;
    end
  end

  // Primitive state registers, updated on each accepted word.
  always_ff @(posedge clk) begin
    if (rst) begin
      anchor    <= '0;
      older     <= '0;
      newer     <= '0;
      pos       <= 2'd0;
      open_kind <= KIND_LIST;
    end else if (accept) begin
      anchor    <= anchor_next;
      older     <= older_next;
      newer     <= newer_next;
      pos       <= pos_next;
      open_kind <= kind_eff;
    end
  end

endmodule

[rtl/pta_queue.sv]
// Short job queue that decouples the front end from the output stage.
// Depends on pta_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "primitive_triangle_assembler_defines.svh"
module pta_queue import pta_pkg::*; #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] wdata,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         q_valid,
  output logic         q_full
);

  localparam int PW = $clog2(QDEPTH);

  logic [W-1:0]  mem [QDEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   count;

  assign q_valid = (count != '0);
  assign q_full  = (count == (PW+1)'(QDEPTH));
  assign rdata   = mem[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + (PW+1)'(1);
      end else if (pop && !push) begin
        count <= count - (PW+1)'(1);
      end
    end
  end

  `PTA_ASSERT_ALWAYS(a_count_bound, count <= (PW+1)'(QDEPTH), "queue count over depth")
  `PTA_ASSERT_ALWAYS(a_no_push_full, !(push && q_full), "push into full queue")
  `PTA_ASSERT_ALWAYS(a_no_pop_empty, !(pop && !q_valid), "pop from empty queue")

endmodule

[rtl/pta_back.sv]
// Output stage: turns queued jobs into triangle words in an output register.
// Depends on pta_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "primitive_triangle_assembler_defines.svh"
module pta_back import pta_pkg::*; #(
  parameter int HB = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  input  logic [HB-1:0]       job_h0,
  input  logic [HB-1:0]       job_h1,
  input  logic [HB-1:0]       job_h2,
  input  logic [HB-1:0]       job_h3,
  input  job_flags_t          job_flags,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [VTX_BITS-1:0] corner_a,
  output logic [VTX_BITS-1:0] corner_b,
  output logic [VTX_BITS-1:0] corner_c,
  output logic                skip_notice,
  output logic                run_end
);

  logic [HB-1:0] out_a;
  logic [HB-1:0] out_b;
  logic [HB-1:0] out_c;
  logic          out_skip;
  logic          out_end;
  logic          phase;
  logic          load;

  // The output register takes a new word when empty or being drained.
  assign load = q_valid && (!out_valid || out_ready);
  // A quad job leaves the queue only after its second triangle.
  assign pop  = load && (!job_flags.two || phase);

  // Output register and quad phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      phase     <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
      phase     <= job_flags.two && !phase;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Word payload; a skip word carries zero corners.
  always_ff @(posedge clk) begin
    if (load) begin
      out_skip <= job_flags.skip;
      if (job_flags.skip) begin
        out_a   <= '0;
        out_b   <= '0;
        out_c   <= '0;
        out_end <= 1'b1;
      end else if (phase) begin
        out_a   <= job_h0;
        out_b   <= job_h2;
        out_c   <= job_h3;
        out_end <= 1'b1;
      end else begin
        out_a   <= job_h0;
        out_b   <= job_h1;
        out_c   <= job_h2;
        out_end <= !job_flags.two;
      end
    end
  end

  assign corner_a    = VTX_BITS'(out_a);
  assign corner_b    = VTX_BITS'(out_b);
  assign corner_c    = VTX_BITS'(out_c);
  assign skip_notice = out_skip;
  assign run_end     = out_end;

  `PTA_ASSERT_ALWAYS(a_phase_job, !phase || (q_valid && job_flags.two), "phase without quad job")
  `PTA_ASSERT_ALWAYS(a_skip_word, !(out_valid && out_skip) || (out_end && out_a == '0),
                     "malformed skip word")
  `PTA_ASSERT_NEXT(a_quad_split, load && !phase && job_flags.two, phase && !out_end,
                   "quad first half not followed by second")

endmodule

[rtl/primitive_triangle_assembler.sv]
// Top level of the primitive triangle assembler: front end, job queue, output stage.
// Depends on pta_pkg, pta_front, pta_queue and pta_back.
//
//  Channel | Handshake               | Word
//  --------+-------------------------+-------------------------------------------------
//  input   | in_valid / in_ready     | vertex_handle, prim_kind, prim_first, prim_last
//  output  | out_valid / out_ready   | corner_a, corner_b, corner_c, skip_notice, run_end
//
// One vertex word is taken per cycle while the four-entry job queue has room.
// A job is written into the job queue when its last vertex is taken, then loaded into the output register.
// The output stage emits one triangle word per cycle while out_ready is high; a quad takes two of them.
// Reset (rst, synchronous) empties the queue and clears the primitive state.
// A stalled output fills the queue, after which in_ready drops.
`timescale 1ns / 1ps
module primitive_triangle_assembler import pta_pkg::*; #(
  parameter int HANDLE_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [VTX_BITS-1:0]  vertex_handle,
  input  logic [KIND_BITS-1:0] prim_kind,
  input  logic                 prim_first,
  input  logic                 prim_last,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [VTX_BITS-1:0]  corner_a,
  output logic [VTX_BITS-1:0]  corner_b,
  output logic [VTX_BITS-1:0]  corner_c,
  output logic                 skip_notice,
  output logic                 run_end
);

  // Handles are kept only to the bits that can reach the output.
  localparam int HB = (HANDLE_BITS < VTX_BITS) ? HANDLE_BITS : VTX_BITS;
  localparam int JW = 4 * HB + $bits(job_flags_t);

  logic          push;
  logic          pop;
  logic          q_valid;
  logic          q_full;
  logic [HB-1:0] f_h0, f_h1, f_h2, f_h3;
  logic [HB-1:0] b_h0, b_h1, b_h2, b_h3;
  job_flags_t    f_flags, b_flags;
  logic [JW-1:0] q_wdata;
  logic [JW-1:0] q_rdata;

  // Front end: vertex state and job formation.
  pta_front #(.HB(HB)) u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .vertex_handle (vertex_handle),
    .prim_kind     (prim_kind),
    .prim_first    (prim_first),
    .prim_last     (prim_last),
    .q_full        (q_full),
    .push          (push),
    .job_h0        (f_h0),
    .job_h1        (f_h1),
    .job_h2        (f_h2),
    .job_h3        (f_h3),
    .job_flags     (f_flags)
  );

  // Pack and unpack queue entries.
  assign q_wdata = {f_h0, f_h1, f_h2, f_h3, f_flags};
  assign {b_h0, b_h1, b_h2, b_h3, b_flags} = q_rdata;

  pta_queue #(.W(JW)) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wdata   (q_wdata),
    .pop     (pop),
    .rdata   (q_rdata),
    .q_valid (q_valid),
    .q_full  (q_full)
  );

  // Output stage.
  pta_back #(.HB(HB)) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .job_h0      (b_h0),
    .job_h1      (b_h1),
    .job_h2      (b_h2),
    .job_h3      (b_h3),
    .job_flags   (b_flags),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .corner_a    (corner_a),
    .corner_b    (corner_b),
    .corner_c    (corner_c),
    .skip_notice (skip_notice),
    .run_end     (run_end)
  );

endmodule
